[rtl/dzce_pkg.sv]
// ----------------------------------------------------------------------------
// Depth zero-cross erosion package
// Item types of the stream channels and register index codes.
// ----------------------------------------------------------------------------
package dzce_pkg;

    typedef struct packed {
        logic        action;
        logic [15:0] depth_value;
    } in_item_t;

    typedef struct packed {
        logic [15:0] depth_out;
        logic        frame_end;
    } out_item_t;

    typedef enum logic [7:0] {
        REG_FRAME_WIDTH  = 8'd0,
        REG_FRAME_HEIGHT = 8'd1,
        REG_X_REACH      = 8'd2,
        REG_Y_REACH      = 8'd3
    } reg_index_t;

    localparam logic ACT_PIXEL = 1'b0;

endpackage

[rtl/dzce_ram.sv]
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module dzce_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/dzce_fifo.sv]
// ----------------------------------------------------------------------------
// Small register FIFO
// Valid/ready on both sides, with a fill level for credit checks.
// ----------------------------------------------------------------------------
module dzce_fifo #(
    parameter int  DEPTH  = 4,
    parameter type item_t = logic
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       wr_valid,
    output logic                       wr_ready,
    input  item_t                      wr_data,
    output logic                       rd_valid,
    input  logic                       rd_ready,
    output item_t                      rd_data,
    output logic [$clog2(DEPTH+1)-1:0] level
);

    localparam int PW = $clog2(DEPTH);
    localparam int LW = $clog2(DEPTH + 1);

    item_t         slot_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [LW-1:0] count_reg, count_next;
    logic          push, pop;

    assign wr_ready = (count_reg != LW'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = slot_reg[rd_ptr_reg];
    assign level    = count_reg;
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + LW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - LW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

[rtl/dzce_front.sv]
// ----------------------------------------------------------------------------
// Depth zero-cross erosion front end
// Holds the registers and all position counters, classifies each transfer
// and issues one command per step into the queue.
// ----------------------------------------------------------------------------
module dzce_front #(
    parameter int  MAX_WIDTH  = 2048,
    parameter int  MAX_HEIGHT = 1024,
    parameter int  MAX_REACH  = 8,
    parameter type cmd_t      = logic
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  dzce_pkg::in_item_t             in_data,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [7:0]                     cfg_index,
    input  logic [11:0]                    cfg_data,
    output logic                           cmd_valid,
    input  logic                           cmd_ready,
    output cmd_t                           cmd,
    output logic                           flush,
    output logic [$clog2(MAX_REACH+1)-1:0] x_reach,
    output logic [$clog2(MAX_REACH+1)-1:0] y_reach
);

    import dzce_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int RW = $clog2(MAX_HEIGHT + 2 * MAX_REACH + 1);
    localparam int XW = $clog2(MAX_REACH + 1);
    localparam int AW = $clog2(MAX_REACH * MAX_WIDTH + 1);

    logic [11:0]   width_reg,  width_next;
    logic [10:0]   height_reg, height_next;
    logic [3:0]    xr_reg,     xr_next;
    logic [3:0]    yr_reg,     yr_next;

    logic [CW-1:0] in_col_reg, in_col_next;
    logic [RW-1:0] in_row_reg, in_row_next;
    logic [CW-1:0] s_col_reg,  s_col_next;
    logic [RW-1:0] s_row_reg,  s_row_next;
    logic [CW-1:0] o_col_reg,  o_col_next;
    logic [RW-1:0] o_row_reg,  o_row_next;
    logic [XW-1:0] s_cnt_reg,  s_cnt_next;
    logic [AW-1:0] wptr_reg,   wptr_next;
    logic [AW-1:0] rptr_reg,   rptr_next;

    logic [WW-1:0] eff_w;
    logic [RW-1:0] eff_h;
    logic [XW-1:0] xr_eff, yr_eff;
    logic          cfg_we, cfg_hit;
    logic          take, step, in_frame, s_fire, out_fire, last;

    assign cfg_ready = 1'b1;
    assign in_ready  = cmd_ready;
    assign cfg_we    = cfg_valid && cfg_ready;
    assign x_reach   = xr_eff;
    assign y_reach   = yr_eff;

    always_comb
    begin
        eff_w = (width_reg == '0) ? WW'(1)
              : ((32'(width_reg) > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(width_reg));
        eff_h = (height_reg == '0) ? RW'(1)
              : ((32'(height_reg) > MAX_HEIGHT) ? RW'(MAX_HEIGHT) : RW'(height_reg));
        xr_eff = (32'(xr_reg) > MAX_REACH) ? XW'(MAX_REACH) : XW'(xr_reg);
        yr_eff = (32'(yr_reg) > MAX_REACH) ? XW'(MAX_REACH) : XW'(yr_reg);
    end

    // Once the whole frame is in, every transfer pushes the pipeline on by one.
    always_comb
    begin
        take     = in_valid && in_ready;
        in_frame = (in_row_reg < eff_h);
        step     = take && (!in_frame || (in_data.action == ACT_PIXEL));
        s_fire   = (in_row_reg >= RW'(yr_eff));
        out_fire = s_fire && (s_cnt_reg >= xr_eff);
        last     = out_fire && (o_row_reg == eff_h - RW'(1))
                 && (WW'(o_col_reg) == eff_w - WW'(1));
    end

    always_comb
    begin
        cmd            = '0;
        cmd.ring_we    = in_frame;
        cmd.ring_waddr = wptr_reg;
        cmd.pixel      = in_data.depth_value;
        cmd.lz_we      = in_frame && ((in_data.depth_value == '0) || (in_row_reg == '0));
        cmd.lz_zero    = (in_data.depth_value == '0);
        cmd.lz_waddr   = in_col_reg;
        cmd.lz_row     = in_row_reg;
        cmd.s_fire     = s_fire;
        cmd.ring_raddr = rptr_reg;
        cmd.s_valid    = (s_row_reg < eff_h);
        cmd.s_col      = s_col_reg;
        cmd.s_row      = s_row_reg;
        cmd.out_fire   = out_fire;
        cmd.last       = last;
        cmd_valid      = step;
    end

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        xr_next     = xr_reg;
        yr_next     = yr_reg;
        cfg_hit     = 1'b0;
        if (cfg_we)
        begin
            cfg_hit = 1'b1;
            case (reg_index_t'(cfg_index))
                REG_FRAME_WIDTH:  width_next  = cfg_data;
                REG_FRAME_HEIGHT: height_next = cfg_data[10:0];
                REG_X_REACH:      xr_next     = cfg_data[3:0];
                REG_Y_REACH:      yr_next     = cfg_data[3:0];
                default:          cfg_hit     = 1'b0;
            endcase
        end
    end

    assign flush = cfg_hit;

    always_comb
    begin
        in_col_next = in_col_reg;
        in_row_next = in_row_reg;
        s_col_next  = s_col_reg;
        s_row_next  = s_row_reg;
        o_col_next  = o_col_reg;
        o_row_next  = o_row_reg;
        s_cnt_next  = s_cnt_reg;
        wptr_next   = wptr_reg;
        rptr_next   = rptr_reg;
        if (step)
        begin
            if (in_frame)
            begin
                wptr_next = wptr_reg + AW'(1);
            end
            if (WW'(in_col_reg) == eff_w - WW'(1))
            begin
                in_col_next = '0;
                in_row_next = in_row_reg + RW'(1);
            end
            else
            begin
                in_col_next = in_col_reg + CW'(1);
            end
            if (s_fire)
            begin
                rptr_next = rptr_reg + AW'(1);
                if (s_cnt_reg < xr_eff)
                begin
                    s_cnt_next = s_cnt_reg + XW'(1);
                end
                if (WW'(s_col_reg) == eff_w - WW'(1))
                begin
                    s_col_next = '0;
                    s_row_next = s_row_reg + RW'(1);
                end
                else
                begin
                    s_col_next = s_col_reg + CW'(1);
                end
            end
            if (out_fire)
            begin
                if (WW'(o_col_reg) == eff_w - WW'(1))
                begin
                    o_col_next = '0;
                    o_row_next = o_row_reg + RW'(1);
                end
                else
                begin
                    o_col_next = o_col_reg + CW'(1);
                end
            end
        end
        if ((step && last) || cfg_hit)
        begin
            in_col_next = '0;
            in_row_next = '0;
            s_col_next  = '0;
            s_row_next  = '0;
            o_col_next  = '0;
            o_row_next  = '0;
            s_cnt_next  = '0;
            wptr_next   = '0;
            rptr_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 12'd640;
            height_reg <= 11'd480;
            xr_reg     <= 4'd1;
            yr_reg     <= 4'd1;
            in_col_reg <= '0;
            in_row_reg <= '0;
            s_col_reg  <= '0;
            s_row_reg  <= '0;
            o_col_reg  <= '0;
            o_row_reg  <= '0;
            s_cnt_reg  <= '0;
            wptr_reg   <= '0;
            rptr_reg   <= '0;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
            xr_reg     <= xr_next;
            yr_reg     <= yr_next;
            in_col_reg <= in_col_next;
            in_row_reg <= in_row_next;
            s_col_reg  <= s_col_next;
            s_row_reg  <= s_row_next;
            o_col_reg  <= o_col_next;
            o_row_reg  <= o_row_next;
            s_cnt_reg  <= s_cnt_next;
            wptr_reg   <= wptr_next;
            rptr_reg   <= rptr_next;
        end
    end

endmodule

[rtl/dzce_back.sv]
// ----------------------------------------------------------------------------
// Depth zero-cross erosion back end
// Pixel ring and per-column last-zero store, a horizontal window of taps,
// and the output FIFO. Commands are popped only when the FIFO has room.
// ----------------------------------------------------------------------------
module dzce_back #(
    parameter int  MAX_WIDTH  = 2048,
    parameter int  MAX_HEIGHT = 1024,
    parameter int  MAX_REACH  = 8,
    parameter type cmd_t      = logic
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cmd_valid,
    output logic                           cmd_ready,
    input  cmd_t                           cmd,
    input  logic                           flush,
    input  logic [$clog2(MAX_REACH+1)-1:0] x_reach,
    input  logic [$clog2(MAX_REACH+1)-1:0] y_reach,
    output logic                           out_valid,
    input  logic                           out_ready,
    output dzce_pkg::out_item_t            out_data
);

    import dzce_pkg::*;

    localparam int RW    = $clog2(MAX_HEIGHT + 2 * MAX_REACH + 1);
    localparam int AW    = $clog2(MAX_REACH * MAX_WIDTH + 1);
    localparam int NTAP  = 2 * MAX_REACH + 1;
    localparam int TW    = $clog2(NTAP);
    localparam int ODEPTH = 4;
    localparam int LW    = $clog2(ODEPTH + 1);

    typedef struct packed {
        logic          zero;
        logic [RW-1:0] row;
    } lz_t;

    typedef struct packed {
        logic [RW-1:0] row;
        logic [15:0]   value;
        logic          vert;
    } tap_t;

    logic          pop;
    logic [LW-1:0] olevel;
    logic [15:0]   ring_rdata;
    lz_t           lz_wdata, lz_rdata;

    logic          st1_fire_reg, st1_out_reg, st1_last_reg;
    logic          st1_svalid_reg;
    logic [RW-1:0] st1_row_reg;
    logic          st1_rbyp_reg, st1_lbyp_reg;
    logic [15:0]   st1_pix_reg;
    lz_t           st1_lz_reg;
    logic          st2_out_reg, st2_last_reg;

    logic          tap_valid_reg [NTAP];
    logic          tap_valid_next [NTAP];
    tap_t          tap_reg [NTAP];

    logic [15:0]   s_value;
    lz_t           s_lz;
    logic          s_vert;
    tap_t          center;
    logic          hit;
    out_item_t     result;
    logic          clear;

    assign cmd_ready = (32'(olevel) + 32'(st1_out_reg) + 32'(st2_out_reg)) < ODEPTH;
    assign pop       = cmd_valid && cmd_ready;

    assign lz_wdata.zero = cmd.lz_zero;
    assign lz_wdata.row  = cmd.lz_row;

    dzce_ram #(
        .WIDTH (16),
        .DEPTH (2 ** AW)
    ) u_ring (
        .clk   (clk),
        .we    (pop && cmd.ring_we),
        .waddr (cmd.ring_waddr),
        .wdata (cmd.pixel),
        .raddr (cmd.ring_raddr),
        .rdata (ring_rdata)
    );

    dzce_ram #(
        .WIDTH ($bits(lz_t)),
        .DEPTH (MAX_WIDTH)
    ) u_last_zero (
        .clk   (clk),
        .we    (pop && cmd.lz_we),
        .waddr (cmd.lz_waddr),
        .wdata (lz_wdata),
        .raddr (cmd.s_col),
        .rdata (lz_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st1_fire_reg <= 1'b0;
            st1_out_reg  <= 1'b0;
            st1_last_reg <= 1'b0;
            st2_out_reg  <= 1'b0;
            st2_last_reg <= 1'b0;
        end
        else
        begin
            st1_fire_reg <= pop && cmd.s_fire;
            st1_out_reg  <= pop && cmd.out_fire;
            st1_last_reg <= pop && cmd.last;
            st2_out_reg  <= st1_out_reg;
            st2_last_reg <= st1_last_reg;
        end
    end

    // The step that writes a location may also read it; the write data wins.
    always_ff @(posedge clk)
    begin
        st1_svalid_reg <= cmd.s_valid;
        st1_row_reg    <= cmd.s_row;
        st1_pix_reg    <= cmd.pixel;
        st1_rbyp_reg   <= cmd.ring_we && (cmd.ring_waddr == cmd.ring_raddr);
        st1_lbyp_reg   <= cmd.lz_we && (cmd.lz_waddr == cmd.s_col);
        st1_lz_reg     <= lz_wdata;
    end

    // The newest zero in the column lies at most y_reach rows below this row, so
    // the column holds a zero within reach exactly when it is not too far above.
    always_comb
    begin
        s_value = st1_rbyp_reg ? st1_pix_reg : ring_rdata;
        s_lz    = st1_lbyp_reg ? st1_lz_reg : lz_rdata;
        s_vert  = s_lz.zero
               && (({1'b0, s_lz.row} + (RW + 1)'(y_reach)) >= {1'b0, st1_row_reg});
    end

    assign clear = (st2_out_reg && st2_last_reg) || flush;

    always_comb
    begin
        for (int t = 0; t < NTAP; t++)
        begin
            tap_valid_next[t] = clear ? 1'b0 : tap_valid_reg[t];
        end
        if (st1_fire_reg)
        begin
            tap_valid_next[0] = st1_svalid_reg;
            for (int t = 1; t < NTAP; t++)
            begin
                tap_valid_next[t] = clear ? 1'b0 : tap_valid_reg[t-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int t = 0; t < NTAP; t++)
            begin
                tap_valid_reg[t] <= 1'b0;
            end
        end
        else
        begin
            for (int t = 0; t < NTAP; t++)
            begin
                tap_valid_reg[t] <= tap_valid_next[t];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (st1_fire_reg)
        begin
            tap_reg[0].row   <= st1_row_reg;
            tap_reg[0].value <= s_value;
            tap_reg[0].vert  <= s_vert;
            for (int t = 1; t < NTAP; t++)
            begin
                tap_reg[t] <= tap_reg[t-1];
            end
        end
    end

    // Tap x_reach is the pixel going out; taps on either side within reach
    // that sit in the same row are its horizontal neighbors.
    always_comb
    begin
        center = tap_reg[TW'(x_reach)];
        hit    = center.vert;
        for (int t = 0; t < NTAP; t++)
        begin
            if ((t <= 2 * int'(x_reach)) && tap_valid_reg[t]
                && (tap_reg[t].row == center.row) && (tap_reg[t].value == '0))
            begin
                hit = 1'b1;
            end
        end
        result.depth_out = hit ? '0 : center.value;
        result.frame_end = st2_last_reg;
    end

    dzce_fifo #(
        .DEPTH  (ODEPTH),
        .item_t (out_item_t)
    ) u_out_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (st2_out_reg),
        .wr_ready (),
        .wr_data  (result),
        .rd_valid (out_valid),
        .rd_ready (out_ready),
        .rd_data  (out_data),
        .level    (olevel)
    );

endmodule

[rtl/depth_zero_cross_erosion_core.sv]
// ----------------------------------------------------------------------------
// Depth zero-cross erosion core
// Forces a depth pixel to zero when a zero lies within reach in its row or
// column. A result is offered once the transfer y_reach rows plus x_reach
// pixels later has passed the command queue, memory reads and tap window.
// Throughput: one item per cycle when not stalled, set by the single write and
// read port of the pixel ring and of the per-column last-zero memory.
// Reset clears all counters and restores the register defaults; memories
// need no clearing pass, as each column entry is rewritten on the first row.
// ----------------------------------------------------------------------------
module depth_zero_cross_erosion_core #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 1024,
    parameter int MAX_REACH  = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  dzce_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output dzce_pkg::out_item_t out_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [7:0]          cfg_index,
    input  logic [11:0]         cfg_data
);

    import dzce_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT + 2 * MAX_REACH + 1);
    localparam int XW = $clog2(MAX_REACH + 1);
    localparam int AW = $clog2(MAX_REACH * MAX_WIDTH + 1);

    typedef struct packed {
        logic          ring_we;
        logic [AW-1:0] ring_waddr;
        logic [15:0]   pixel;
        logic          lz_we;
        logic          lz_zero;
        logic [CW-1:0] lz_waddr;
        logic [RW-1:0] lz_row;
        logic          s_fire;
        logic [AW-1:0] ring_raddr;
        logic          s_valid;
        logic [CW-1:0] s_col;
        logic [RW-1:0] s_row;
        logic          out_fire;
        logic          last;
    } cmd_t;

    cmd_t          f_cmd, b_cmd;
    logic          f_valid, f_ready, b_valid, b_ready;
    logic          flush;
    logic [XW-1:0] x_reach, y_reach;

    dzce_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .MAX_REACH  (MAX_REACH),
        .cmd_t      (cmd_t)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd_valid (f_valid),
        .cmd_ready (f_ready),
        .cmd       (f_cmd),
        .flush     (flush),
        .x_reach   (x_reach),
        .y_reach   (y_reach)
    );

    dzce_fifo #(
        .DEPTH  (4),
        .item_t (cmd_t)
    ) u_cmd_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (f_valid),
        .wr_ready (f_ready),
        .wr_data  (f_cmd),
        .rd_valid (b_valid),
        .rd_ready (b_ready),
        .rd_data  (b_cmd),
        .level    ()
    );

    dzce_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .MAX_REACH  (MAX_REACH),
        .cmd_t      (cmd_t)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (b_valid),
        .cmd_ready (b_ready),
        .cmd       (b_cmd),
        .flush     (flush),
        .x_reach   (x_reach),
        .y_reach   (y_reach),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

[rtl/dzce_checker.sv]
// ----------------------------------------------------------------------------
// Depth zero-cross erosion port checker
// Watches the top-level ports for reset and flow-control behavior.
// ----------------------------------------------------------------------------
module dzce_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input dzce_pkg::out_item_t out_data,
    input logic                cfg_ready
);

    // After a reset edge nothing is pending, so no result is offered.
    a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
        else $error("result offered after reset");

    // An empty command queue after reset takes a transfer at once.
    a_reset_ready: assert property (@(posedge clk) !rst_n |=> in_ready)
        else $error("input not ready after reset");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
        else $error("configuration port stalled");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("stalled result changed");

endmodule

bind depth_zero_cross_erosion_core dzce_checker u_checker (.*);

[tb/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Depth zero-cross erosion testbench
// Streams depth frames through the core under several frame shapes and reach
// settings, predicts every eroded pixel with a behavioral copy of the block,
// and compares each output transfer in order against it.
// ----------------------------------------------------------------------------
module testbench;
    import dzce_pkg::*;

    localparam int MAX_W      = 2048;
    localparam int MAX_H      = 1024;
    localparam int MAX_R      = 8;
    localparam int RING_SIZE  = MAX_R * MAX_W + MAX_R + 1;
    localparam int SINCE_FULL = 31;
    localparam int SETTLE     = 24;
    localparam int LIMIT      = 600000;
    localparam int RANDOM_ITEMS = 1550;
    localparam logic [7:0] REG_UNUSED = 8'd9;
    localparam logic ACT_DRAIN = 1'b1;

    // Results of one predicted item.
    localparam int STEP_IGNORED = 0;
    localparam int STEP_SILENT  = 1;
    localparam int STEP_OUTPUT  = 2;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    in_item_t   in_data = '0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    out_item_t  out_data;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [7:0] cfg_index = '0;
    logic [11:0] cfg_data = '0;

    depth_zero_cross_erosion_core dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #10 clk = ~clk;

    // Behavioral copy of the erosion state.
    int unsigned      set_width, set_height, set_xr, set_yr;
    logic [15:0]      pix_ring [RING_SIZE];
    int unsigned      col_zero_dist [MAX_W];
    int unsigned      row_zero_dist;
    int unsigned      in_col, in_row, out_col, out_row;
    out_item_t        pending_pixels [$];

    int errors = 0;
    int cycles = 0;
    int sender_idle_pct = 0;
    int receiver_stall_pct = 0;
    int random_items = 0;

    function automatic int unsigned frame_w();
        if (set_width == 0) return 1;
        return (set_width > MAX_W) ? MAX_W : set_width;
    endfunction

    function automatic int unsigned frame_h();
        if (set_height == 0) return 1;
        return (set_height > MAX_H) ? MAX_H : set_height;
    endfunction

    function automatic int unsigned clamp_reach(int unsigned r);
        return (r > MAX_R) ? MAX_R : r;
    endfunction

    function automatic void restart_frame();
        for (int i = 0; i < MAX_W; i++) col_zero_dist[i] = SINCE_FULL;
        row_zero_dist = SINCE_FULL;
        in_col = 0;
        in_row = 0;
        out_col = 0;
        out_row = 0;
    endfunction

    function automatic void apply_reg(logic [7:0] idx, logic [11:0] value);
        case (idx)
            REG_FRAME_WIDTH:  set_width  = value;
            REG_FRAME_HEIGHT: set_height = value[10:0];
            REG_X_REACH:      set_xr     = value[3:0];
            REG_Y_REACH:      set_yr     = value[3:0];
            default:          return;
        endcase
        restart_frame();
    endfunction

    function automatic int erode_step(input logic act, input logic [15:0] v,
                                      output out_item_t res);
        int unsigned w, h, xr, yr, lag, pos, p, ox, oy;
        logic [15:0] cur;
        bit zero;
        w = frame_w();
        h = frame_h();
        xr = clamp_reach(set_xr);
        yr = clamp_reach(set_yr);
        lag = yr * w + xr;
        res = '0;
        pos = in_row * w + in_col;
        if (in_row < h) begin
            if (act == ACT_DRAIN) return STEP_IGNORED;
            pix_ring[pos % RING_SIZE] = v;
        end else if (out_row >= h) begin
            return STEP_IGNORED;
        end
        in_col++;
        if (in_col >= w) begin
            in_col = 0;
            in_row++;
        end
        if (pos < lag) return STEP_SILENT;

        ox = out_col;
        oy = out_row;
        p = oy * w + ox;
        cur = pix_ring[p % RING_SIZE];
        zero = (row_zero_dist <= xr) || (col_zero_dist[ox] <= yr);
        for (int j = 0; j <= xr; j++)
            if (ox + j < w && pix_ring[(p + j) % RING_SIZE] == 16'd0) zero = 1'b1;
        for (int k = 1; k <= yr; k++)
            if (oy + k < h && pix_ring[(p + k * w) % RING_SIZE] == 16'd0) zero = 1'b1;
        if (cur == 16'd0) begin
            row_zero_dist = 1;
            col_zero_dist[ox] = 1;
        end else begin
            if (row_zero_dist < SINCE_FULL) row_zero_dist++;
            if (col_zero_dist[ox] < SINCE_FULL) col_zero_dist[ox]++;
        end
        res.depth_out = zero ? 16'd0 : cur;
        res.frame_end = (p == w * h - 1);
        out_col++;
        if (out_col >= w) begin
            out_col = 0;
            out_row++;
            row_zero_dist = SINCE_FULL;
        end
        if (res.frame_end) restart_frame();
        return STEP_OUTPUT;
    endfunction

    // Waits until every predicted pixel has left the core, plus pipeline slack.
    task automatic wait_quiet();
        while (pending_pixels.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(logic [7:0] idx, logic [11:0] value);
        wait_quiet();
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = value;
        do @(posedge clk); while (!cfg_ready);
        apply_reg(idx, value);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Starts at a falling edge and returns at the falling edge after the
    // transfer, so consecutive calls drive items back to back.
    task automatic send_item(logic act, logic [15:0] v, output int kind,
                             output out_item_t res);
        while ($urandom_range(99) < sender_idle_pct) begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        in_data.action = act;
        in_data.depth_value = v;
        do @(posedge clk); while (!in_ready);
        kind = erode_step(act, v, res);
        if (kind == STEP_OUTPUT) pending_pixels = {pending_pixels, res};
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= receiver_stall_pct);

    always @(posedge clk) begin
        out_item_t want;
        cycles <= cycles + 1;
        if (out_valid && out_ready) begin
            if (pending_pixels.size() == 0) begin
                $display("%0t: unexpected transfer depth %h end %b", $time,
                         out_data.depth_out, out_data.frame_end);
                errors++;
            end else begin
                want = pending_pixels.pop_front();
                if (out_data.depth_out !== want.depth_out) begin
                    $display("%0t: depth_out expected %h actual %h", $time,
                             want.depth_out, out_data.depth_out);
                    errors++;
                end
                if (out_data.frame_end !== want.frame_end) begin
                    $display("%0t: frame_end expected %b actual %b", $time,
                             want.frame_end, out_data.frame_end);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk) begin
        if (cycles >= LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic logic [15:0] random_depth();
        return ($urandom_range(99) < 30) ? 16'd0 : 16'($urandom);
    endfunction

    task automatic count_item(int kind);
        if (kind != STEP_IGNORED) random_items++;
    endtask

    // One frame: all pixels, stray drains while it arrives, then drain ticks
    // until the last pixel is out.
    task automatic stream_frame(bit hold_mid);
        int kind;
        out_item_t res;
        int unsigned total;
        total = frame_w() * frame_h();
        for (int unsigned i = 0; i < total; i++) begin
            if ($urandom_range(99) < 5) begin
                send_item(ACT_DRAIN, 16'($urandom), kind, res);
                count_item(kind);
            end
            if (hold_mid && i == total / 2) begin
                while (pending_pixels.size() != 0) @(posedge clk);
                @(negedge clk);
            end
            send_item(ACT_PIXEL, random_depth(), kind, res);
            count_item(kind);
        end
        while (in_row >= frame_h()) begin
            send_item(($urandom_range(99) < 10) ? ACT_PIXEL : ACT_DRAIN,
                      16'($urandom), kind, res);
            count_item(kind);
        end
        if ($urandom_range(99) < 10) begin
            send_item(ACT_DRAIN, 16'($urandom), kind, res);
            count_item(kind);
        end
    endtask

    task automatic run_phase(int mode, logic [11:0] w, logic [11:0] h,
                             logic [11:0] xr, logic [11:0] yr, int frames,
                             bit hold_mid);
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        case (mode)
            1: sender_idle_pct = 54;
            2: receiver_stall_pct = 54;
            3: begin sender_idle_pct = 6; receiver_stall_pct = 6; end
            default: ;
        endcase
        write_reg(REG_FRAME_WIDTH, w);
        write_reg(REG_FRAME_HEIGHT, h);
        write_reg(REG_X_REACH, xr);
        write_reg(REG_Y_REACH, yr);
        if ($urandom_range(99) < 15) write_reg(8'($urandom_range(255, 4)), 12'($urandom));
        for (int f = 0; f < frames; f++) stream_frame(hold_mid && f == 0);
    endtask

    typedef struct {
        bit          is_reg;
        logic [7:0]  idx;
        logic [11:0] value;
        logic        act;
        logic [15:0] depth;
        bit          typed;
        out_item_t   want;
    } plan_row_t;

    plan_row_t plan [] = '{
        '{1, REG_FRAME_WIDTH,  12'd1,  0, 0, 0, '0},
        '{1, REG_FRAME_HEIGHT, 12'd1,  0, 0, 0, '0},
        '{1, REG_X_REACH,      12'd0,  0, 0, 0, '0},
        '{1, REG_Y_REACH,      12'd0,  0, 0, 0, '0},
        '{0, 0, 0, ACT_PIXEL, 16'h0005, 1, '{16'h0005, 1'b1}},
        '{0, 0, 0, ACT_PIXEL, 16'h0000, 1, '{16'h0000, 1'b1}},
        '{0, 0, 0, ACT_PIXEL, 16'hFFFF, 1, '{16'hFFFF, 1'b1}},
        '{0, 0, 0, ACT_DRAIN, 16'hFFFF, 0, '0},
        '{1, REG_FRAME_WIDTH,  12'd3,  0, 0, 0, '0},
        '{1, REG_FRAME_HEIGHT, 12'd2,  0, 0, 0, '0},
        '{1, REG_X_REACH,      12'd1,  0, 0, 0, '0},
        '{1, REG_Y_REACH,      12'd1,  0, 0, 0, '0},
        '{0, 0, 0, ACT_PIXEL, 16'h0007, 0, '0},
        '{0, 0, 0, ACT_DRAIN, 16'h0000, 0, '0},
        '{0, 0, 0, ACT_PIXEL, 16'h0000, 0, '0},
        '{0, 0, 0, ACT_PIXEL, 16'h8001, 0, '0},
        '{0, 0, 0, ACT_PIXEL, 16'h1234, 0, '0},
        '{0, 0, 0, ACT_PIXEL, 16'h4321, 0, '0},
        '{0, 0, 0, ACT_PIXEL, 16'h7FFE, 0, '0},
        '{0, 0, 0, ACT_PIXEL, 16'h5555, 0, '0},
        '{0, 0, 0, ACT_DRAIN, 16'h0000, 0, '0},
        '{0, 0, 0, ACT_DRAIN, 16'h0000, 0, '0},
        '{0, 0, 0, ACT_DRAIN, 16'h0000, 0, '0},
        '{0, 0, 0, ACT_DRAIN, 16'h0000, 0, '0},
        '{1, REG_UNUSED,       12'd5,  0, 0, 0, '0}
    };

    initial begin
        int kind;
        out_item_t res;
        int phase;
        set_width = 640;
        set_height = 480;
        set_xr = 1;
        set_yr = 1;
        for (int i = 0; i < RING_SIZE; i++) pix_ring[i] = '0;
        restart_frame();
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (plan[i]) begin
            if (plan[i].is_reg) begin
                write_reg(plan[i].idx, plan[i].value);
            end else begin
                send_item(plan[i].act, plan[i].depth, kind, res);
                if (plan[i].typed && (kind != STEP_OUTPUT || res !== plan[i].want)) begin
                    $display("%0t: row %0d expected %h actual %h", $time, i,
                             plan[i].want, res);
                    errors++;
                end
            end
        end

        // Register extremes, including zero sizes and reaches that saturate.
        run_phase(0, 12'd0,  12'd0,  12'd0,  12'd0,  2, 0);
        run_phase(2, 12'd3,  12'd2,  12'd15, 12'd15, 1, 0);
        run_phase(1, 12'd1,  12'd12, 12'd0,  12'd8,  1, 0);
        run_phase(3, 12'd16, 12'd1,  12'd8,  12'd0,  1, 0);
        run_phase(0, 12'd5,  12'd16, 12'd8,  12'd8,  1, 0);

        phase = 0;
        while (random_items < RANDOM_ITEMS) begin
            run_phase(phase % 4,
                      ($urandom_range(19) == 0) ? 12'd0
                        : 12'($urandom_range(($urandom_range(4) == 0) ? 40 : 10, 1)),
                      12'($urandom_range(6, 1)),
                      12'(($urandom_range(9) == 0) ? $urandom_range(15, 9)
                                                   : $urandom_range(8)),
                      12'(($urandom_range(9) == 0) ? $urandom_range(15, 9)
                                                   : $urandom_range(8)),
                      $urandom_range(2, 1), phase == 1);
            phase++;
        end

        while (pending_pixels.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule

[sim.f]
rtl/dzce_pkg.sv
rtl/dzce_ram.sv
rtl/dzce_fifo.sv
rtl/dzce_front.sv
rtl/dzce_back.sv
rtl/depth_zero_cross_erosion_core.sv
rtl/dzce_checker.sv
tb/testbench.sv
